/* rtl/swsd_pkg.sv */
package swsd_pkg;

   localparam int unsigned NUM_DIGITS  = 4;
   localparam int unsigned STEP_W      = $clog2(NUM_DIGITS);
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned FS_W        = 14;
   localparam int unsigned VALUE_W     = 14;
   localparam int unsigned PROD_W      = SAMPLE_W + FS_W;
   localparam int unsigned SEG_W       = 8;
   localparam int unsigned WEIGHT_W    = 10;
   localparam int unsigned DIGIT_W     = 4;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_CLEAR   = 2'd1;
   localparam logic [1:0] OP_REFRESH = 2'd2;

   localparam logic [FS_W-1:0]    FS_RESET    = 14'd3300;
   localparam logic [5:0]         SEC_WRAP    = 6'd60;
   localparam logic [6:0]         MIN_WRAP    = 7'd100;
   localparam logic [VALUE_W-1:0] DISPLAY_MOD = 14'd10000;
   localparam logic [SEG_W-1:0]   DP_MASK     = 8'h80;

   typedef struct packed {
      logic                show_voltage;
      logic [SAMPLE_W-1:0] value;
   } q_entry_type;

   // active-low common-anode patterns, a..g in bits 0..6
   function automatic logic [SEG_W-1:0] seg_lookup(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 8'hC0;
         4'd1:    s = 8'hF9;
         4'd2:    s = 8'hA4;
         4'd3:    s = 8'hB0;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h92;
         4'd6:    s = 8'h82;
         4'd7:    s = 8'hF8;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h90;
         default: s = 8'hFF;
      endcase
      return s;
   endfunction

   // decimal weight of a digit position, leftmost first
   function automatic logic [WEIGHT_W-1:0] digit_weight(input logic [STEP_W-1:0] step);
      logic [WEIGHT_W-1:0] w;
      case (step)
         2'd0:    w = 10'd1000;
         2'd1:    w = 10'd100;
         2'd2:    w = 10'd10;
         default: w = 10'd1;
      endcase
      return w;
   endfunction

endpackage

/* rtl/stopwatch_seven_segment_display.sv */
// channel  | valid/ready              | tdata            | tuser                 | tlast
// req      | req_tvalid / req_tready  | adc_sample       | op, show_voltage      | -
// rsp      | rsp_tvalid / rsp_tready  | segment_pattern  | digit_select          | last_digit
// csr      | csr_we                   | csr_wdata = full_scale_mv
//
// Tick and clear words skip the queue and update the time when accepted, while the queue is not full.
// A refresh gives four frames from the digit sequencer, one per cycle unless the output stalls;
// the sequencer takes the next refresh value as it emits the last frame of the one before.
// A refresh word passes the queue, multiply, scale, sequencer and output registers in that order.
// Synchronous active-high reset; time cleared, full scale back to 3300 mV.
// A two-entry queue decouples the input from the stalled output side.
module stopwatch_seven_segment_display (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,   // adc_sample [15:0], zero pad
   input  logic [2:0]                     req_tuser,   // op [1:0], show_voltage [2]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // segment_pattern [7:0]
   output logic [3:0]                     rsp_tuser,   // digit_select [3:0]
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [13:0]                    csr_wdata
);

   logic                    push_valid, q_full, pop_valid, pop_ready;
   swsd_pkg::q_entry_type   push_entry, pop_entry;

   swsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   swsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   swsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/swsd_front.sv */
module swsd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [23:0]               req_tdata,   // adc_sample, zero pad
   input  logic [2:0]                req_tuser,   // op, show_voltage
   input  logic                      q_full,
   output logic                      push_valid,
   output swsd_pkg::q_entry_type     push_entry
);

   logic [5:0]                      second_ff, second_in, sec_inc;
   logic [6:0]                      minute_ff, minute_in, min_inc;
   logic [swsd_pkg::VALUE_W-1:0]    time_value;
   logic                            accept;
   logic [1:0]                      op;

   assign op         = req_tuser[1:0];
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign sec_inc    = second_ff + 6'd1;
   assign min_inc    = minute_ff + 7'd1;

   // capture the time as it stands when the refresh word arrives
   assign time_value = ({7'd0, minute_ff} * 14'd100) + {8'd0, second_ff};

   assign push_valid              = accept && (op == swsd_pkg::OP_REFRESH);
   assign push_entry.show_voltage = req_tuser[2];
   assign push_entry.value        = req_tuser[2] ? req_tdata[15:0] : {2'd0, time_value};

   always_comb begin
      second_in = second_ff;
      minute_in = minute_ff;
      if (accept) begin
         unique case (op)
            swsd_pkg::OP_TICK: begin
               if (sec_inc >= swsd_pkg::SEC_WRAP) begin
                  second_in = 6'd0;
                  minute_in = (min_inc >= swsd_pkg::MIN_WRAP) ? 7'd0 : min_inc;
               end else begin
                  second_in = sec_inc;
               end
            end
            swsd_pkg::OP_CLEAR: begin
               second_in = 6'd0;
               minute_in = 7'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 6'd0;
         minute_ff <= 7'd0;
      end else begin
         second_ff <= second_in;
         minute_ff <= minute_in;
      end
   end

endmodule

/* rtl/swsd_queue.sv */
module swsd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  swsd_pkg::q_entry_type     push_entry,
   output logic                      full,
   input  logic                      pop_ready,
   output logic                      pop_valid,
   output swsd_pkg::q_entry_type     pop_entry
);

   swsd_pkg::q_entry_type            entries_ff [swsd_pkg::QUEUE_DEPTH];
   logic [swsd_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [swsd_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             do_push, do_pop;

   assign full      = (count_ff == swsd_pkg::QCNT_W'(swsd_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == swsd_pkg::QPTR_W'(swsd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == swsd_pkg::QPTR_W'(swsd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("word pushed into full queue");
`endif

endmodule

/* rtl/swsd_back.sv */
module swsd_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [swsd_pkg::FS_W-1:0]      csr_wdata,
   input  logic                           pop_valid,
   input  swsd_pkg::q_entry_type          pop_entry,
   output logic                           pop_ready,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [swsd_pkg::SEG_W-1:0]     rsp_tdata,
   output logic [swsd_pkg::NUM_DIGITS-1:0] rsp_tuser,
   output logic                           rsp_tlast
);

   logic [swsd_pkg::FS_W-1:0]       fs_ff;

   // stage A: scale multiply
   logic                            a_valid_ff, a_valid_in, a_volt_ff, a_ready;
   logic [swsd_pkg::PROD_W-1:0]     a_prod_ff, a_prod_in;

   // stage B: divide by full code, wrap to four digits
   logic                            b_valid_ff, b_valid_in, b_volt_ff, b_ready;
   logic [swsd_pkg::VALUE_W-1:0]    b_value_ff, b_value_in, mv, raw;
   logic [swsd_pkg::PROD_W:0]       scale_sum;

   // stage C: digit sequencer
   logic                            seq_busy_ff, seq_busy_in, c_volt_ff, c_volt_in;
   logic [swsd_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [swsd_pkg::VALUE_W-1:0]    rem_ff, rem_in, rem_next;
   logic [swsd_pkg::WEIGHT_W-1:0]   weight;
   logic [swsd_pkg::DIGIT_W-1:0]    digit;
   logic                            c_take, emit, out_load, last_step;
   logic [swsd_pkg::SEG_W-1:0]      seg;

   // output register
   logic                            out_valid_ff, out_valid_in, last_ff;
   logic [swsd_pkg::SEG_W-1:0]      seg_ff;
   logic [swsd_pkg::NUM_DIGITS-1:0] sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= swsd_pkg::FS_RESET;
      end else if (csr_we) begin
         fs_ff <= csr_wdata;
      end
   end

   // stage A
   assign a_ready    = !a_valid_ff || b_ready;
   assign pop_ready  = a_ready;
   assign a_valid_in = a_ready ? pop_valid : a_valid_ff;
   assign a_prod_in  = pop_entry.show_voltage ?
                       ({14'd0, pop_entry.value} * {16'd0, fs_ff}) :
                       {14'd0, pop_entry.value};

   // stage B: floor(p / 65535) = (p + (p >> 16) + 1) >> 16 for p below 2^30
   assign b_ready    = !b_valid_ff || c_take;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign scale_sum  = {1'b0, a_prod_ff} + {17'd0, a_prod_ff[29:16]} + 31'd1;
   assign mv         = scale_sum[29:16];
   assign raw        = a_volt_ff ? mv : a_prod_ff[swsd_pkg::VALUE_W-1:0];
   assign b_value_in = (raw >= swsd_pkg::DISPLAY_MOD) ? raw - swsd_pkg::DISPLAY_MOD : raw;

   // stage C
   assign out_load  = !out_valid_ff || rsp_tready;
   assign emit      = seq_busy_ff && out_load;
   assign last_step = (step_ff == swsd_pkg::STEP_W'(swsd_pkg::NUM_DIGITS - 1));
   assign c_take    = b_valid_ff && (!seq_busy_ff || (emit && last_step));
   assign weight    = swsd_pkg::digit_weight(step_ff);

   always_comb begin
      digit = '0;
      for (int d = 1; d <= 9; d++) begin
         if (rem_ff >= swsd_pkg::VALUE_W'(weight * d)) begin
            digit = swsd_pkg::DIGIT_W'(d);
         end
      end
   end

   assign rem_next = rem_ff - ({4'd0, weight} * {10'd0, digit});

   always_comb begin
      seg = swsd_pkg::seg_lookup(digit);
      // light the point on digit 0 for volts, digit 1 for time
      if ((c_volt_ff && step_ff == 2'd0) || (!c_volt_ff && step_ff == 2'd1)) begin
         seg = seg & ~swsd_pkg::DP_MASK;
      end
   end

   always_comb begin
      seq_busy_in = seq_busy_ff;
      step_in     = step_ff;
      rem_in      = rem_ff;
      c_volt_in   = c_volt_ff;
      if (c_take) begin
         seq_busy_in = 1'b1;
         step_in     = '0;
         rem_in      = b_value_ff;
         c_volt_in   = b_volt_ff;
      end else if (emit) begin
         if (last_step) begin
            seq_busy_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
            rem_in  = rem_next;
         end
      end
   end

   assign out_valid_in = out_load ? seq_busy_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         seq_busy_ff  <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         seq_busy_ff  <= seq_busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_prod_ff <= a_prod_in;
         a_volt_ff <= pop_entry.show_voltage;
      end
      if (b_ready) begin
         b_value_ff <= b_value_in;
         b_volt_ff  <= a_volt_ff;
      end
      rem_ff    <= rem_in;
      c_volt_ff <= c_volt_in;
      if (emit) begin
         seg_ff  <= seg;
         sel_ff  <= swsd_pkg::NUM_DIGITS'(1) << step_ff;
         last_ff <= last_step;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = seg_ff;
   assign rsp_tuser  = sel_ff;
   assign rsp_tlast  = last_ff;

`ifndef ASSERT_OFF
   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      seq_busy_ff |-> (rem_ff < ({4'd0, weight} * 14'd10)))
      else $error("remainder exceeds digit position");

   a_wrapped_value: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_value_ff < swsd_pkg::DISPLAY_MOD))
      else $error("display value not wrapped");

   a_last_on_right: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ($onehot(sel_ff) && (last_ff == sel_ff[swsd_pkg::NUM_DIGITS-1])))
      else $error("frame select and last marker disagree");

   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      (emit && !last_step) |=> (seq_busy_ff && (step_ff == $past(step_ff) + 2'd1)))
      else $error("sequencer skipped a digit");
`endif

endmodule

/* tb/display_frame_checker.sv */
`timescale 1ns / 1ps

module display_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // adc_sample [15:0], zero pad
   input  logic [2:0]  req_tuser,   // op [1:0], show_voltage [2]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // segment_pattern [7:0]
   input  logic [3:0]  rsp_tuser,   // digit_select [3:0]
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [13:0] csr_wdata,
   output int          mismatches,
   output int          frames_pending,
   output int          frames_checked
);

   typedef struct packed {
      logic [7:0] pattern;
      logic [3:0] select;
      logic       last;
   } frame_type;

   frame_type   frames_due[$];
   logic [5:0]  seconds;
   logic [6:0]  minutes;
   logic [13:0] full_scale;

   initial begin
      mismatches     = 0;
      frames_pending = 0;
      frames_checked = 0;
   end

   // common anode: a lit segment is a zero bit
   function automatic logic [7:0] glyph(input int unsigned d);
      logic [7:0] lit;
      case (d)
         0:       lit = 8'h3F;
         1:       lit = 8'h06;
         2:       lit = 8'h5B;
         3:       lit = 8'h4F;
         4:       lit = 8'h66;
         5:       lit = 8'h6D;
         6:       lit = 8'h7D;
         7:       lit = 8'h07;
         8:       lit = 8'h7F;
         default: lit = 8'h6F;
      endcase
      return ~lit;
   endfunction

   task automatic queue_digits(input int unsigned shown, input int unsigned point_at);
      int unsigned v;
      int unsigned place;
      frame_type   f;
      v     = shown % 10000;
      place = 1000;
      for (int i = 0; i < 4; i++) begin
         f.pattern = glyph((v / place) % 10);
         if (i == point_at) f.pattern[7] = 1'b0;
         f.select  = 4'b0001 << i;
         f.last    = (i == 3);
         frames_due.push_back(f);
         place = place / 10;
      end
   endtask

   task automatic note_mismatch(input frame_type want, input bit stray);
      mismatches++;
      if (mismatches <= 10) begin
         if (stray)
            $display("%0t: frame with nothing due: pattern %h select %h last %b",
                     $realtime, rsp_tdata, rsp_tuser, rsp_tlast);
         else
            $display("%0t: frame mismatch: want pattern %h select %h last %b, got %h %h %b",
                     $realtime, want.pattern, want.select, want.last,
                     rsp_tdata, rsp_tuser, rsp_tlast);
      end
   endtask

   always @(posedge clock) begin
      frame_type   want;
      logic [29:0] product;
      if (reset) begin
         seconds    = '0;
         minutes    = '0;
         full_scale = swsd_pkg::FS_RESET;
         frames_due.delete();
      end else begin
         if (csr_we) full_scale = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (frames_due.size() == 0) begin
               want = '0;
               note_mismatch(want, 1'b1);
            end else begin
               want = frames_due.pop_front();
               frames_checked++;
               if (rsp_tdata !== want.pattern || rsp_tuser !== want.select ||
                   rsp_tlast !== want.last)
                  note_mismatch(want, 1'b0);
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser[1:0])
               swsd_pkg::OP_TICK: begin
                  seconds = seconds + 6'd1;
                  if (seconds >= 6'd60) begin
                     seconds = '0;
                     minutes = minutes + 7'd1;
                     if (minutes >= 7'd100) minutes = '0;
                  end
               end
               swsd_pkg::OP_CLEAR: begin
                  seconds = '0;
                  minutes = '0;
               end
               swsd_pkg::OP_REFRESH: begin
                  if (req_tuser[2]) begin
                     product = req_tdata[15:0] * full_scale;
                     queue_digits(32'(product / 30'd65535), 0);
                  end else begin
                     queue_digits(minutes * 100 + seconds, 1);
                  end
               end
               default: ;
            endcase
         end
      end
      frames_pending = frames_due.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         PHASE_WORDS  = 22;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [13:0] csr_wdata;

   int mismatches;
   int frames_pending;
   int frames_checked;
   int hold_requests;
   int refresh_words;
   int other_words;
   int settings_used;

   stopwatch_seven_segment_display uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   display_frame_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .frames_pending (frames_pending),
      .frames_checked (frames_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb failed");
      $finish;
   end

   // output side: short and long stalls, calm stretches, and a long hold on request
   initial begin
      int hold_left;
      int stall_left;
      int calm_left;
      int holds_seen;
      int r;
      hold_left  = 0;
      stall_left = 0;
      calm_left  = 0;
      holds_seen = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = 150;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(20, 80);
            r = $urandom_range(0, 99);
            if (calm_left == 0 && r < 15) begin
               stall_left = $urandom_range(0, 2);
               rsp_tready <= 1'b0;
            end else if (calm_left == 0 && r < 18) begin
               stall_left = $urandom_range(8, 30);
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // enter and leave at a falling edge; valid stays high for a following word
   task automatic send_word(input logic [1:0] op, input logic volt, input logic [15:0] sample);
      req_tdata  <= {8'd0, sample};
      req_tuser  <= {volt, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (op == swsd_pkg::OP_REFRESH) refresh_words++;
      else other_words++;
   endtask

   task automatic pause(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   // hold input until every frame is out, then let a trailing tick or clear settle
   task automatic drain();
      req_tvalid <= 1'b0;
      wait (frames_pending == 0);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_full_scale(input logic [13:0] mv);
      drain();
      csr_wdata <= mv;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h0000;
      if (r < 20) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic random_word(input bit calm);
      int r;
      int burst;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         send_word(swsd_pkg::OP_REFRESH, 1'($urandom_range(0, 1)), pick_sample());
      end else if (r < 75) begin
         send_word(swsd_pkg::OP_TICK, 1'($urandom_range(0, 1)), pick_sample());
      end else if (r < 82) begin
         send_word(swsd_pkg::OP_CLEAR, 1'($urandom_range(0, 1)), pick_sample());
      end else if (r < 88) begin
         send_word(OP_UNUSED, 1'($urandom_range(0, 1)), pick_sample());
      end else begin
         burst = $urandom_range(3, 8);
         repeat (burst) send_word(swsd_pkg::OP_TICK, 1'($urandom_range(0, 1)), pick_sample());
      end
      if (!calm) pause(sender_gap());
   endtask

   initial begin
      logic [13:0] phase_scale;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      hold_requests = 0;
      refresh_words = 0;
      other_words   = 0;
      settings_used = 1;
      reset         = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset time, sample extremes, unused op, full-scale extremes
      send_word(swsd_pkg::OP_REFRESH, 1'b0, 16'h0000);
      send_word(swsd_pkg::OP_REFRESH, 1'b1, 16'h0000);
      send_word(swsd_pkg::OP_REFRESH, 1'b1, 16'hFFFF);
      send_word(swsd_pkg::OP_REFRESH, 1'b1, 16'h5555);
      send_word(swsd_pkg::OP_REFRESH, 1'b1, 16'hAAAA);
      send_word(OP_UNUSED, 1'b1, 16'hFFFF);
      send_word(swsd_pkg::OP_REFRESH, 1'b0, 16'hFFFF);
      repeat (3) send_word(swsd_pkg::OP_TICK, 1'b0, 16'h0000);
      send_word(swsd_pkg::OP_REFRESH, 1'b0, 16'h0000);
      send_word(swsd_pkg::OP_CLEAR, 1'b1, 16'hFFFF);
      send_word(swsd_pkg::OP_REFRESH, 1'b0, 16'h8000);
      send_word(swsd_pkg::OP_REFRESH, 1'b1, 16'h8000);
      write_full_scale(14'h3FFF);
      send_word(swsd_pkg::OP_REFRESH, 1'b1, 16'hFFFF);
      write_full_scale(14'd0);
      send_word(swsd_pkg::OP_REFRESH, 1'b1, 16'hFFFF);
      write_full_scale(14'd9999);
      send_word(swsd_pkg::OP_REFRESH, 1'b1, 16'hFFFF);
      write_full_scale(14'd1);
      send_word(swsd_pkg::OP_REFRESH, 1'b1, 16'hFFFF);
      send_word(swsd_pkg::OP_REFRESH, 1'b1, 16'hFFFE);

      // run the seconds through their wrap and carry into the first minute
      send_word(swsd_pkg::OP_CLEAR, 1'b0, 16'h0000);
      for (int k = 1; k <= 61; k++) begin
         send_word(swsd_pkg::OP_TICK, 1'b0, 16'h0000);
         if (k >= 59)
            send_word(swsd_pkg::OP_REFRESH, 1'b0, 16'h0000);
      end

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       phase_scale = 14'h3FFF;
            1:       phase_scale = 14'd0;
            2:       phase_scale = 14'd9999;
            3:       phase_scale = 14'($urandom_range(0, 16383));
            4:       phase_scale = 14'd1;
            default: phase_scale = swsd_pkg::FS_RESET;
         endcase
         write_full_scale(phase_scale);
         if (phase == 1) begin
            // stall the output side and keep offering refreshes so the queue backs up
            hold_requests++;
            repeat (12) send_word(swsd_pkg::OP_REFRESH, 1'($urandom_range(0, 1)), pick_sample());
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            random_word(phase == 3);
            if ($urandom_range(0, 99) < 3) begin
               req_tvalid <= 1'b0;
               wait (frames_pending == 0);
               @(negedge clock);
            end
         end
      end

      req_tvalid <= 1'b0;
      wait (frames_pending == 0);
      repeat (20) @(posedge clock);
      $display("covered %0d refresh words and %0d tick, clear and unused words over %0d scales",
               refresh_words, other_words, settings_used);
      $display("checked %0d frames, through a minute carry and a long output stall",
               frames_checked);
      if (mismatches == 0 && frames_pending == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
